@@ rtl/core/mnafix_pkg.sv @@
// Shared constants, codes and helper functions for the masked neighbor average unit.
// Used by the top level and by its port checker; depends on nothing else.
`default_nettype none

package mnafix_pkg;

  // Grid storage and value format.
  localparam int MAX_X      = 16;
  localparam int MAX_Y      = 16;
  localparam int MAX_Z      = 16;
  localparam int VALUE_BITS = 32;

  localparam int CELL_COUNT = MAX_X * MAX_Y * MAX_Z;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  // Fixed field widths of the ports.
  localparam int COORD_W   = 4;
  localparam int SIZE_W    = 5;
  localparam int FIELD_W   = 32;
  localparam int CFG_IDX_W = 2;

  // Internal arithmetic widths.
  localparam int NBR_W     = COORD_W + 2;
  localparam int WEIGHT_W  = 4;
  localparam int WSUM_W    = 8;
  localparam int SUM_W     = VALUE_BITS + 8;
  localparam int DIV_CNT_W = $clog2(SUM_W + 1);

  // Item commands.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  // Linear cell address, x fastest, then y, then z.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                  input logic [COORD_W-1:0] y,
                                                  input logic [COORD_W-1:0] z);
    logic [31:0] idx;
    idx = (32'(z) * 32'(MAX_Y) + 32'(y)) * 32'(MAX_X) + 32'(x);
    return idx[ADDR_W-1:0];
  endfunction

  // Inverse distance weights, scaled to integers (1, 1/2, 1/3, 1/4 times 12).
  function automatic logic [WEIGHT_W-1:0] weight_of(input logic [1:0] hops);
    logic [WEIGHT_W-1:0] w;
    case (hops)
      2'd0:    w = 4'd12;
      2'd1:    w = 4'd6;
      2'd2:    w = 4'd4;
      default: w = 4'd3;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/masked_neighbor_average_fix_unit.sv @@
// Top level of the masked neighbor average unit: cell storage, neighbor walk and divider.
// Depends on mnafix_pkg.
`default_nettype none

// The unit stores a 16x16x16 grid of Q16.16 cells, each with a failed mark,
// in one single-port-read memory with a registered read. A load transfer writes
// one cell; the unit is ready again in the next cycle and produces no result.
// A query transfer of a good cell returns its stored value, read in ST_CENTER
// and passed through ST_FIN to the output register. A query of a failed cell
// walks the 27 positions of its 3x3x3 neighborhood through the memory read
// port, one read per cycle, and accumulates weight times value for every good
// neighbor inside the configured size; it then divides the sum by the weight
// sum in a restoring divider that retires one quotient bit per cycle, or
// returns the cell's own value if no good neighbor was found. The unit takes
// one item at a time: in_stall is high from a query's transfer until its result
// sits in the output register, and the output register lets the next item be
// taken while that result waits for its transfer. Configuration writes (grid
// size per axis) belong to idle periods.
// There is no clearing pass after reset: cells must be loaded before they are read.
module masked_neighbor_average_fix_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Item input channel.
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_command,
  input  logic [mnafix_pkg::COORD_W-1:0]       in_cell_x,
  input  logic [mnafix_pkg::COORD_W-1:0]       in_cell_y,
  input  logic [mnafix_pkg::COORD_W-1:0]       in_cell_z,
  input  logic signed [mnafix_pkg::FIELD_W-1:0] in_load_value,
  input  logic                                 in_load_failed,
  // Result channel.
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [mnafix_pkg::FIELD_W-1:0] out_fixed_value,
  output logic                                 out_cell_was_failed,
  output logic                                 out_no_good_neighbour,
  // Configuration write port.
  input  logic                                 cfg_we,
  input  logic [mnafix_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mnafix_pkg::SIZE_W-1:0]        cfg_wdata
);
  import mnafix_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CENTER,
    ST_WALK,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t state_r;

  // Configuration.
  logic [SIZE_W-1:0] size_x_r, size_y_r, size_z_r;

  // Cell storage: failed mark on top of the value.
  logic [VALUE_BITS:0] mem_r [CELL_COUNT];
  logic [VALUE_BITS:0] rd_data_r;
  logic [ADDR_W-1:0]   rd_addr;

  // Latched query.
  logic [COORD_W-1:0] x_r, y_r, z_r;
  logic signed [VALUE_BITS-1:0] cval_r;

  // Neighbor walk.
  logic [1:0]          ox_r, oy_r, oz_r;
  logic                issue_r;
  logic                pend_vld_r;
  logic                pend_in_r;
  logic [WEIGHT_W-1:0] pend_w_r;
  logic signed [SUM_W-1:0] acc_r;
  logic [WSUM_W-1:0]   wsum_r;

  // Divider.
  logic [WSUM_W:0]     rem_r;
  logic [SUM_W-1:0]    quo_r;
  logic                neg_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;

  // Staged result and output register.
  logic signed [FIELD_W-1:0] res_value_r;
  logic                      res_failed_r;
  logic                      res_nogood_r;
  logic                      out_valid_r;
  logic signed [FIELD_W-1:0] out_value_r;
  logic                      out_failed_r;
  logic                      out_nogood_r;

  // Combinational helpers.
  logic                      in_xfer;
  logic                      in_range;
  logic [ADDR_W-1:0]         in_addr;
  logic [NBR_W-1:0]          nx, ny, nz;
  logic                      nbr_inside;
  logic [ADDR_W-1:0]         nbr_addr;
  logic [1:0]                nbr_dist;
  logic                      walk_last;
  logic signed [VALUE_BITS-1:0] rd_value;
  logic                      rd_failed;
  logic signed [VALUE_BITS+WEIGHT_W:0] prod;
  logic                      nbr_use;
  logic signed [SUM_W-1:0]   acc_nxt;
  logic [WSUM_W-1:0]         wsum_nxt;
  logic [WSUM_W:0]           div_shift;
  logic                      div_ge;
  logic [WSUM_W:0]           rem_nxt;
  logic [SUM_W-1:0]          quo_nxt;
  logic [SUM_W-1:0]          quo_signed;
  logic                      out_free;

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  assign in_range = (32'(in_cell_x) < 32'(MAX_X)) && (32'(in_cell_y) < 32'(MAX_Y)) &&
                    (32'(in_cell_z) < 32'(MAX_Z));
  assign in_addr  = cell_addr(in_cell_x, in_cell_y, in_cell_z);

  // Neighbor coordinates; an offset below zero wraps high and falls outside.
  assign nx = NBR_W'(x_r) + NBR_W'(ox_r) - NBR_W'(1);
  assign ny = NBR_W'(y_r) + NBR_W'(oy_r) - NBR_W'(1);
  assign nz = NBR_W'(z_r) + NBR_W'(oz_r) - NBR_W'(1);

  assign nbr_inside = (nx < {1'b0, size_x_r}) && (nx < NBR_W'(MAX_X)) &&
                      (ny < {1'b0, size_y_r}) && (ny < NBR_W'(MAX_Y)) &&
                      (nz < {1'b0, size_z_r}) && (nz < NBR_W'(MAX_Z));
  assign nbr_addr   = cell_addr(nx[COORD_W-1:0], ny[COORD_W-1:0], nz[COORD_W-1:0]);
  assign nbr_dist   = {1'b0, ox_r != 2'd1} + {1'b0, oy_r != 2'd1} + {1'b0, oz_r != 2'd1};
  assign walk_last  = (ox_r == 2'd2) && (oy_r == 2'd2) && (oz_r == 2'd2);

  assign rd_addr   = (state_r == ST_IDLE) ? in_addr : nbr_addr;
  assign rd_value  = $signed(rd_data_r[VALUE_BITS-1:0]);
  assign rd_failed = rd_data_r[VALUE_BITS];

  // Weighted accumulation of the neighbor read in the previous cycle.
  assign prod     = $signed({1'b0, pend_w_r}) * rd_value;
  assign nbr_use  = pend_vld_r && pend_in_r && !rd_failed;
  assign acc_nxt  = nbr_use ? acc_r + SUM_W'(prod) : acc_r;
  assign wsum_nxt = nbr_use ? wsum_r + WSUM_W'(pend_w_r) : wsum_r;

  // One restoring division step on the magnitude.
  assign div_shift  = {rem_r[WSUM_W-1:0], quo_r[SUM_W-1]};
  assign div_ge     = div_shift >= {1'b0, wsum_r};
  assign rem_nxt    = div_ge ? div_shift - {1'b0, wsum_r} : div_shift;
  assign quo_nxt    = {quo_r[SUM_W-2:0], div_ge};
  assign quo_signed = neg_r ? SUM_W'(0) - quo_nxt : quo_nxt;

  // The output register can take a new result at this edge.
  assign out_free = !out_valid_r || !out_stall;

  assign out_valid             = out_valid_r;
  assign out_fixed_value       = out_value_r;
  assign out_cell_was_failed   = out_failed_r;
  assign out_no_good_neighbour = out_nogood_r;

  // Cell storage: one write port for loads, one registered read port.
  always_ff @(posedge clk) begin
    if (in_xfer && (in_command == CMD_LOAD) && in_range) begin
      mem_r[in_addr] <= {in_load_failed, VALUE_BITS'(in_load_value)};
    end
    rd_data_r <= mem_r[rd_addr];
  end

  // Sequencer, datapath registers and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      size_x_r    <= SIZE_RESET;
      size_y_r    <= SIZE_RESET;
      size_z_r    <= SIZE_RESET;
      out_valid_r <= 1'b0;
      issue_r     <= 1'b0;
      pend_vld_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SIZE_X: size_x_r <= cfg_wdata;
          CFG_SIZE_Y: size_y_r <= cfg_wdata;
          CFG_SIZE_Z: size_z_r <= cfg_wdata;
          default: ;
        endcase
      end

      // A result leaving while a new one moves in is handled in ST_FIN.
      if (out_valid_r && !out_stall && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_xfer && (in_command == CMD_QUERY)) begin
            x_r <= in_cell_x;
            y_r <= in_cell_y;
            z_r <= in_cell_z;
            if (in_range) begin
              state_r <= ST_CENTER;
            end else begin
              // A cell outside storage answers with all fields zero.
              res_value_r  <= '0;
              res_failed_r <= 1'b0;
              res_nogood_r <= 1'b0;
              state_r      <= ST_FIN;
            end
          end
        end

        ST_CENTER: begin
          cval_r <= rd_value;
          if (!rd_failed) begin
            res_value_r  <= FIELD_W'(rd_value);
            res_failed_r <= 1'b0;
            res_nogood_r <= 1'b0;
            state_r      <= ST_FIN;
          end else begin
            ox_r       <= 2'd0;
            oy_r       <= 2'd0;
            oz_r       <= 2'd0;
            issue_r    <= 1'b1;
            pend_vld_r <= 1'b0;
            acc_r      <= '0;
            wsum_r     <= '0;
            state_r    <= ST_WALK;
          end
        end

        ST_WALK: begin
          acc_r      <= acc_nxt;
          wsum_r     <= wsum_nxt;
          pend_vld_r <= issue_r;
          if (issue_r) begin
            pend_in_r <= nbr_inside;
            pend_w_r  <= weight_of(nbr_dist);
            if (walk_last) begin
              issue_r <= 1'b0;
            end
            if (ox_r == 2'd2) begin
              ox_r <= 2'd0;
              if (oy_r == 2'd2) begin
                oy_r <= 2'd0;
                oz_r <= oz_r + 2'd1;
              end else begin
                oy_r <= oy_r + 2'd1;
              end
            end else begin
              ox_r <= ox_r + 2'd1;
            end
          end else if (!pend_vld_r) begin
            // All 27 positions are in; divide or fall back to the own value.
            if (wsum_r == '0) begin
              res_value_r  <= FIELD_W'(cval_r);
              res_failed_r <= 1'b1;
              res_nogood_r <= 1'b1;
              state_r      <= ST_FIN;
            end else begin
              neg_r     <= acc_r[SUM_W-1];
              quo_r     <= acc_r[SUM_W-1] ? SUM_W'(0) - acc_r : acc_r;
              rem_r     <= '0;
              div_cnt_r <= DIV_CNT_W'(SUM_W);
              state_r   <= ST_DIV;
            end
          end
        end

        ST_DIV: begin
          rem_r     <= rem_nxt;
          quo_r     <= quo_nxt;
          div_cnt_r <= div_cnt_r - DIV_CNT_W'(1);
          if (div_cnt_r == DIV_CNT_W'(1)) begin
            // Quotient of magnitudes with the sign put back truncates toward zero.
            res_value_r  <= FIELD_W'(quo_signed);
            res_failed_r <= 1'b1;
            res_nogood_r <= 1'b0;
            state_r      <= ST_FIN;
          end
        end

        ST_FIN: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_value_r  <= res_value_r;
            out_failed_r <= res_failed_r;
            out_nogood_r <= res_nogood_r;
            state_r      <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/mnafix_checker.sv @@
// Port-level checker for the masked neighbor average unit, with its bind statement.
// Depends on mnafix_pkg and on masked_neighbor_average_fix_unit.
`default_nettype none

module mnafix_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 in_command,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [mnafix_pkg::FIELD_W-1:0] out_fixed_value,
  input logic                                 out_cell_was_failed,
  input logic                                 out_no_good_neighbour
);
  import mnafix_pkg::*;

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_fixed_value) &&
      $stable(out_cell_was_failed) && $stable(out_no_good_neighbour))
    else $error("stalled result changed or dropped");

  // Only a failed cell can lack good neighbors.
  a_nogood_needs_failed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_good_neighbour |-> out_cell_was_failed)
    else $error("no_good_neighbour set on a good cell");

  // A query keeps the unit busy in the next cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_command == CMD_QUERY) |=> in_stall)
    else $error("unit ready right after a query transfer");

  // A load completes in its own cycle.
  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_command == CMD_LOAD) |=> !in_stall)
    else $error("unit busy after a load transfer");

endmodule

bind masked_neighbor_average_fix_unit mnafix_checker u_mnafix_checker (.*);

`default_nettype wire
